// ===== design/lpfd_pkg.sv =====
`timescale 1ns / 1ps

package lpfd_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int COUNT_W = 5;
    localparam int WORD_W = 32;

    localparam logic [COUNT_W-1:0] HDR_LAST = COUNT_W'(HEADER_BYTES - 1);

    // header word index, taken from the byte position
    localparam logic [2:0] WORD_VERSION = 3'd0;
    localparam logic [2:0] WORD_TYPE    = 3'd1;
    localparam logic [2:0] WORD_SIZE    = 3'd3;

    localparam logic [WORD_W-1:0] VERSION_ONE = 32'd1;
    localparam logic [WORD_W-1:0] TYPE_STREAM = 32'd110;
    localparam logic [WORD_W-1:0] TYPE_END    = 32'd112;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_HEADER  = 2'b01,
        ST_PAYLOAD = 2'b10
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } in_beat_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

endpackage

// ===== design/length_prefixed_frame_deframer.sv =====
`timescale 1ns / 1ps

// Length-prefixed frame deframer. Takes one link byte per transfer on the
// s_ side; each frame is a 20-byte header of five big-endian words (version,
// type, tag, payload size, identifier) and then the payload. Version-1
// stream-data frames (type 110) put out their payload bytes with tlast on the
// final byte, or one empty-frame marker (tuser 2) if the payload is empty.
// Version-1 end frames (type 112) put out one end marker (tuser 1) on their
// last byte. All other frames are consumed silently. The block takes one byte
// every cycle while the output is not stalled. Each accepted byte is held in
// one input register; the header/payload update (byte position count and
// 32-bit payload down-counter) then loads the output register, which presents
// the result on m_. Back-pressure on m_ stalls the input only when the output
// register is full.
module length_prefixed_frame_deframer
    import lpfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] out_kind
    output logic       m_tlast    // out_last
);

    in_beat_t beat;
    result_t  res;
    logic     out_free;
    logic     step;

    assign step = beat.valid && out_free;

    lpfd_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (step),
        .beat     (beat)
    );

    lpfd_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .beat  (beat),
        .step  (step),
        .res   (res)
    );

    lpfd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .step     (step),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef ASSERT_OFF
    // input side never stalls while the output register can take a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled with output register free");

    // markers carry no byte and no tlast
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != KIND_BYTE) |-> (m_tdata == 8'd0 && !m_tlast))
    else $error("marker result with byte or tlast set");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == KIND_BYTE || m_tuser == KIND_END
                      || m_tuser == KIND_EMPTY))
    else $error("undefined result kind");

    // a byte accepted while m_tready is high steps next cycle unless s_tready drops
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && m_tready) |=> !s_tready || step)
    else $error("accepted byte not advanced");
`endif

endmodule

// ===== design/lpfd_in_reg.sv =====
`timescale 1ns / 1ps

module lpfd_in_reg
    import lpfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       advance,
    output in_beat_t   beat
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            data_reg <= s_tdata;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

// ===== design/lpfd_parse.sv =====
`timescale 1ns / 1ps

module lpfd_parse
    import lpfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_beat_t beat,
    input  logic     step,
    output result_t  res
);

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [WORD_W-1:0]   version_reg;
    logic [WORD_W-1:0]   version_next;
    logic [WORD_W-1:0]   type_reg;
    logic [WORD_W-1:0]   type_next;
    logic [WORD_W-1:0]   size_reg;
    logic [WORD_W-1:0]   size_next;
    logic [WORD_W-1:0]   left_reg;
    logic [WORD_W-1:0]   left_next;
    logic                ok;
    logic                last;
    logic [2:0]          word_idx;

    assign ok       = (version_reg == VERSION_ONE);
    assign word_idx = count_reg[COUNT_W-1:2];
    assign last     = (left_reg <= WORD_W'(1));

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        version_next = version_reg;
        type_next    = type_reg;
        size_next    = size_reg;
        left_next    = left_reg;
        res.valid    = 1'b0;
        res.kind     = KIND_BYTE;
        res.data     = 8'd0;
        res.last     = 1'b0;

        case (phase_reg)
            ST_HEADER:
            begin
                case (word_idx)
                    WORD_VERSION: version_next = {version_reg[WORD_W-9:0], beat.data};
                    WORD_TYPE:    type_next    = {type_reg[WORD_W-9:0], beat.data};
                    WORD_SIZE:    size_next    = {size_reg[WORD_W-9:0], beat.data};
                    default:      ;
                endcase
                if (count_reg != HDR_LAST)
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
                else
                begin
                    // last header byte: the version, type and size words are complete here
                    count_next = '0;
                    if (size_reg != '0)
                    begin
                        left_next  = size_reg;
                        phase_next = ST_PAYLOAD;
                    end
                    else if (ok && type_reg == TYPE_STREAM)
                    begin
                        res.valid = 1'b1;
                        res.kind  = KIND_EMPTY;
                    end
                    else if (ok && type_reg == TYPE_END)
                    begin
                        res.valid = 1'b1;
                        res.kind  = KIND_END;
                    end
                end
            end
            ST_PAYLOAD:
            begin
                if (left_reg != '0)
                begin
                    left_next = left_reg - WORD_W'(1);
                end
                if (last)
                begin
                    phase_next = ST_HEADER;
                end
                if (ok && type_reg == TYPE_STREAM)
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_BYTE;
                    res.data  = beat.data;
                    res.last  = last;
                end
                else if (ok && type_reg == TYPE_END && last)
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_END;
                end
            end
            default:
            begin
                phase_next = ST_HEADER;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= ST_HEADER;
            count_reg   <= '0;
            version_reg <= '0;
            type_reg    <= '0;
            size_reg    <= '0;
            left_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            version_reg <= version_next;
            type_reg    <= type_next;
            size_reg    <= size_next;
            left_reg    <= left_next;
        end
    end

endmodule

// ===== design/lpfd_out_reg.sv =====
`timescale 1ns / 1ps

module lpfd_out_reg
    import lpfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  result_t    res,
    input  logic       step,
    output logic       free,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] out_kind
    output logic       m_tlast    // out_last
);

    logic       valid_reg;
    logic       valid_next;
    kind_t      kind_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = free ? (step && res.valid) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the payload while the consumer stalls
    always_ff @(posedge clk)
    begin
        if (free)
        begin
            kind_reg <= res.kind;
            data_reg <= res.data;
            last_reg <= res.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== dv/deframe_checker.sv =====
`timescale 1ns / 1ps

module deframe_checker
    import lpfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [1:0] m_tuser,
    input  logic       m_tlast,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } deframed_t;

    deframed_t deframed_q[$];

    // mirror of the header/payload tracking in the block
    logic [COUNT_W-1:0] hdr_pos;
    logic [WORD_W-1:0]  ver_w;
    logic [WORD_W-1:0]  type_w;
    logic [WORD_W-1:0]  size_w;
    logic [WORD_W-1:0]  left_cnt;
    logic               in_body;

    int errors;
    int queued;

    assign fail_count = errors;
    assign pending    = queued;

    task automatic expect_result(input kind_t k, input logic [7:0] d, input logic l);
        deframed_t r;
        r.kind = k;
        r.data = d;
        r.last = l;
        deframed_q.insert(deframed_q.size(), r);
    endtask

    task automatic deframe_step(input logic [7:0] b);
        logic ok;
        logic done;
        ok = (ver_w == VERSION_ONE);
        if (!in_body) begin
            case (hdr_pos[4:2])
                WORD_VERSION: ver_w  = {ver_w[23:0], b};
                WORD_TYPE:    type_w = {type_w[23:0], b};
                WORD_SIZE:    size_w = {size_w[23:0], b};
                default: ;
            endcase
            if (hdr_pos != HDR_LAST) begin
                hdr_pos = hdr_pos + 1'b1;
            end
            else begin
                hdr_pos = '0;
                ok = (ver_w == VERSION_ONE);
                if (size_w != '0) begin
                    left_cnt = size_w;
                    in_body  = 1'b1;
                end
                else if (ok && type_w == TYPE_STREAM) begin
                    expect_result(KIND_EMPTY, 8'h00, 1'b0);
                end
                else if (ok && type_w == TYPE_END) begin
                    expect_result(KIND_END, 8'h00, 1'b0);
                end
            end
        end
        else begin
            if (left_cnt != '0)
                left_cnt = left_cnt - 1'b1;
            done = (left_cnt == '0);
            if (done)
                in_body = 1'b0;
            if (ok && type_w == TYPE_STREAM) begin
                expect_result(KIND_BYTE, b, done);
            end
            else if (ok && type_w == TYPE_END && done) begin
                expect_result(KIND_END, 8'h00, 1'b0);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        deframed_t want;
        if (!rst_n) begin
            hdr_pos  = '0;
            ver_w    = '0;
            type_w   = '0;
            size_w   = '0;
            left_cnt = '0;
            in_body  = 1'b0;
            errors   = 0;
            deframed_q.delete();
            queued   = 0;
        end
        else begin
            // results pass through the input and output registers after their bytes, so compare before predicting
            if (m_tvalid && m_tready) begin
                if (deframed_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transfer kind=%0d byte=%h last=%b",
                             $time, m_tuser, m_tdata, m_tlast);
                end
                else begin
                    want = deframed_q.pop_front();
                    if (m_tuser !== want.kind || m_tdata !== want.data
                        || m_tlast !== want.last) begin
                        errors++;
                        $display({"%0t: expected kind=%0d byte=%h last=%b,",
                                  " got kind=%0d byte=%h last=%b"},
                                 $time, want.kind, want.data, want.last,
                                 m_tuser, m_tdata, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                deframe_step(s_tdata);
            queued = deframed_q.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lpfd_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    int fail_count;
    int pending;
    int sent_bytes = 0;
    bit quiet = 1'b0;
    bit feed_gaps = 1'b0;
    bit sink_gaps = 1'b0;
    int stall_left = 0;
    int mode_timer = 0;

    always #1 clk = ~clk;

    length_prefixed_frame_deframer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    deframe_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // sink: stall in bursts, in busy stretches only
    always @(negedge clk)
    begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && sink_gaps && $urandom_range(0, 4) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end
        else begin
            m_tready <= 1'b1;
        end
        if (mode_timer == 0) begin
            sink_gaps  <= ($urandom_range(0, 3) != 0);
            mode_timer <= $urandom_range(20, 120);
        end
        else begin
            mode_timer <= mode_timer - 1;
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!quiet && feed_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        sent_bytes++;
    endtask

    task automatic send_frame(input logic [31:0] ver, input logic [31:0] ftype,
                              input logic [31:0] tag, input logic [31:0] size,
                              input logic [31:0] ident, input bit extreme_fill);
        logic [31:0] words [5];
        logic [7:0]  fill [4];
        words = '{ver, ftype, tag, size, ident};
        fill  = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
        feed_gaps = ($urandom_range(0, 3) != 0);
        // header words go out most significant byte first
        for (int w = 0; w < 5; w++)
            for (int k = 3; k >= 0; k--)
                send_byte(words[w][8*k +: 8]);
        for (int i = 0; i < size; i++)
            send_byte(extreme_fill ? fill[i % 4] : 8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_frame();
        logic [31:0] ver;
        logic [31:0] ftype;
        logic [31:0] size;
        int pick;
        ver = 32'(VERSION_ONE);
        if ($urandom_range(0, 9) == 0)
            ver = $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 3));
        pick = $urandom_range(0, 19);
        if (pick < 12)
            ftype = TYPE_STREAM;
        else if (pick < 15)
            ftype = TYPE_END;
        else if (pick < 17)
            ftype = 32'($urandom_range(0, 255));
        else
            ftype = $urandom();
        pick = $urandom_range(0, 9);
        if (pick == 0)
            size = 0;
        else if (pick < 8)
            size = $urandom_range(1, 8);
        else
            size = $urandom_range(9, 40);
        send_frame(ver, ftype, $urandom(), size, $urandom(), 1'b0);
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        send_frame(VERSION_ONE, TYPE_STREAM, 32'h0, 4, 32'hFFFF_FFFF, 1'b1);
        send_frame(VERSION_ONE, TYPE_STREAM, 32'hFFFF_FFFF, 1, 32'h0, 1'b1);
        send_frame(VERSION_ONE, TYPE_STREAM, 32'h0, 0, 32'h0, 1'b0);
        send_frame(VERSION_ONE, TYPE_END, 32'h0, 0, 32'h0, 1'b0);
        send_frame(VERSION_ONE, TYPE_END, 32'h0, 3, 32'h0, 1'b1);
        // wrong version: skipped whole, with or without payload
        send_frame(32'd2, TYPE_STREAM, 32'h0, 2, 32'h0, 1'b1);
        send_frame(32'd0, TYPE_END, 32'h0, 0, 32'h0, 1'b0);
        send_frame(32'h0100_0001, TYPE_STREAM, 32'h0, 1, 32'h0, 1'b1);
        // other types: payload dropped
        send_frame(VERSION_ONE, 32'd111, 32'h0, 2, 32'h0, 1'b1);
        send_frame(VERSION_ONE, 32'h0100_006E, 32'h0, 0, 32'h0, 1'b0);
        send_frame(VERSION_ONE, TYPE_STREAM, 32'h0, 2, 32'h0, 1'b1);

        while (sent_bytes < 650) begin
            if (sent_bytes >= 560)
                quiet = 1'b1;
            send_random_frame();
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule
